FILE: design/sample_covariance_matrix_assert.svh
// Assertion macros shared by the design files
`ifndef SAMPLE_COVARIANCE_MATRIX_ASSERT_SVH
`define SAMPLE_COVARIANCE_MATRIX_ASSERT_SVH

`define SCM_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");

`define SCM_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");

`endif

FILE: design/scm_pkg.sv
`timescale 1ns / 1ps
package scm_pkg;

  localparam int MAX_DIM    = 8;
  localparam int MAX_POINTS = 65535;
  localparam int FRAC_BITS  = 16;
  localparam int TRI_SIZE   = MAX_DIM * (MAX_DIM + 1) / 2;
  localparam int IDX_W      = 3;
  localparam int TRI_W      = 6;
  localparam int PSUM_W     = 47;
  localparam int CSUM_W     = 32;
  localparam int NUM_W      = 64;
  localparam int DEN_W      = 32;
  localparam int QUO_W      = NUM_W + FRAC_BITS;

  localparam logic [47:0] COV_MAX = 48'h7FFF_FFFF_FFFF;

  localparam logic [0:0] ACT_COORD  = 1'b0;
  localparam logic [0:0] ACT_FINISH = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FEW   = 2'd1;
  localparam logic [1:0] ST_DROP  = 2'd2;

  typedef struct packed {
    logic [0:0]         action;
    logic signed [15:0] coord;
  } scm_in_t;

  typedef struct packed {
    logic [2:0]         row;
    logic [2:0]         col;
    logic signed [47:0] covariance;
    logic [1:0]         status;
    logic [0:0]         last;
  } scm_out_t;

  typedef enum logic [3:0] {
    S_IDLE, S_ACC, S_ACC_RD, S_ACC_WR, S_FIN, S_PROD, S_NUM, S_DIV, S_EMIT, S_CLR
  } scm_state_t;

  typedef struct packed {
    logic        start;
    logic [QUO_W-1:0] dividend;
    logic [DEN_W-1:0] divisor;
  } div_req_t;

  function automatic logic [TRI_W-1:0] tri_index(input logic [IDX_W-1:0] a,
                                                 input logic [IDX_W-1:0] b);
    logic [IDX_W-1:0] i;
    logic [IDX_W-1:0] j;
    logic [TRI_W+2:0] t;
    i = (a > b) ? b : a;
    j = (a > b) ? a : b;
    t = (TRI_W+3)'(i) * (TRI_W+3)'(MAX_DIM)
        - (((TRI_W+3)'(i) * ((TRI_W+3)'(i) - ((i > 0) ? (TRI_W+3)'(1) : '0))) >> 1)
        + (TRI_W+3)'(j - i);
    return t[TRI_W-1:0];
  endfunction

endpackage

FILE: design/scm_divider.sv
`timescale 1ns / 1ps
module scm_divider
  import scm_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  div_req_t         req,
  output logic             done,
  output logic [QUO_W-1:0] quotient
);
  `include "sample_covariance_matrix_assert.svh"

  logic [QUO_W-1:0] quo;
  logic [DEN_W:0]   rem;
  logic [DEN_W-1:0] den;
  logic [6:0]       cnt;
  logic             running;
  logic [DEN_W:0]   trial;

  assign trial = {rem[DEN_W-1:0], quo[QUO_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= running && !req.start && (cnt == 7'd1);
      if (req.start) begin
        running <= 1'b1;
        cnt     <= 7'(QUO_W);
        quo     <= req.dividend;
        rem     <= '0;
        den     <= req.divisor;
      end else if (running) begin
        if (trial >= {1'b0, den}) begin
          rem <= trial - {1'b0, den};
          quo <= {quo[QUO_W-2:0], 1'b1};
        end else begin
          rem <= trial;
          quo <= {quo[QUO_W-2:0], 1'b0};
        end
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          running <= 1'b0;
        end
      end
    end
  end

  assign quotient = quo;

  `SCM_ASSERT_NEXT(a_div_done, clk, rst, running && cnt == 7'd1 && !req.start, done)
  `SCM_ASSERT_IMP(a_div_cnt, clk, rst, running, cnt != 7'd0)
  `SCM_ASSERT_IMP(a_div_excl, clk, rst, done, !running)
endmodule

FILE: design/sample_covariance_matrix.sv
`timescale 1ns / 1ps
// Channel  Signals                       Direction
// config   cfg_valid cfg_ready cfg_data  in, write dims
// command  start busy cmd                in, one coordinate or finish
// result   strobe result                 out, one matrix entry per strobe cycle
// A coordinate passes through S_ACC; one that completes a kept point then does
// a read and a write of the product sums per pair (S_ACC_RD, S_ACC_WR).
// A finish runs S_FIN, S_PROD, S_NUM, S_DIV (bit-serial divider), S_EMIT per entry
// (dims*dims entries, dims taken as 1..8), then clears the product sums and goes idle.
// With fewer than two points the finish skips the divider and just emits each entry.
// Reset is synchronous, then the product sums are cleared with busy high; no stalls.
module sample_covariance_matrix
  import scm_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     cfg_valid,
  output logic     cfg_ready,
  input  logic [3:0] cfg_data,
  input  logic     start,
  output logic     busy,
  input  scm_in_t  cmd,
  output logic     strobe,
  output scm_out_t result
);
  `include "sample_covariance_matrix_assert.svh"

  scm_state_t state, state_next;
  logic [3:0] dims;
  logic [IDX_W-1:0] d1;
  logic signed [15:0] pbuf [MAX_DIM];
  logic [IDX_W-1:0] coord_index;
  logic signed [CSUM_W-1:0] csum [MAX_DIM];
  logic signed [PSUM_W-1:0] psum [TRI_SIZE];
  logic signed [PSUM_W-1:0] psum_q;
  logic signed [PSUM_W-1:0] psum_wd;
  logic psum_we;
  logic signed [31:0] pp;
  logic [15:0] point_count;
  logic dropped;
  logic [IDX_W-1:0] ii, jj;
  logic [TRI_W-1:0] ti;
  logic signed [63:0] prod;
  logic signed [63:0] wide;
  logic [NUM_W-1:0] num;
  logic [NUM_W-1:0] num_mag;
  logic neg;
  logic [DEN_W-1:0] den;
  div_req_t dreq;
  logic ddone;
  logic [QUO_W-1:0] quo;
  logic [47:0] mag;
  logic few;

  always_comb begin
    unique case (1'b1)
      (dims == 4'd0): d1 = '0;
      (dims > 4'(MAX_DIM)): d1 = IDX_W'(MAX_DIM - 1);
      default: d1 = IDX_W'(dims - 4'd1);
    endcase
  end

  assign cfg_ready = (state == S_IDLE);
  assign busy = (state != S_IDLE);
  assign few = (point_count < 16'd2);
  assign ti = tri_index(ii, jj);
  assign pp = pbuf[ii] * pbuf[jj];
  assign psum_we = (state == S_ACC_WR) || (state == S_CLR);
  assign psum_wd = (state == S_CLR) ? '0 : psum_q + PSUM_W'(pp);
  assign num = wide - prod;
  assign num_mag = num[NUM_W-1] ? -num : num;

  always_ff @(posedge clk) begin
    if (psum_we) psum[ti] <= psum_wd;
    psum_q <= psum[ti];
  end

  always_ff @(posedge clk) begin
    if (rst) dims <= 4'd8;
    else if (cfg_valid && cfg_ready) dims <= cfg_data;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (start) state_next = (cmd.action == ACT_FINISH) ? S_FIN : S_ACC;
      S_ACC:    state_next = (coord_index >= d1 && point_count < 16'(MAX_POINTS)) ? S_ACC_RD
                             : S_IDLE;
      S_ACC_RD: state_next = S_ACC_WR;
      S_ACC_WR: state_next = (ii == d1 && jj == d1) ? S_IDLE : S_ACC_RD;
      S_FIN:    state_next = few ? S_EMIT : S_PROD;
      S_PROD:   state_next = S_NUM;
      S_NUM:    state_next = S_DIV;
      S_DIV:    state_next = ddone ? S_EMIT : S_DIV;
      S_EMIT:   state_next = (ii == d1 && jj == d1) ? S_CLR : (few ? S_EMIT : S_FIN);
      S_CLR:    state_next = (ti == TRI_W'(TRI_SIZE - 1)) ? S_IDLE : S_CLR;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    dreq.start    = (state == S_NUM);
    dreq.dividend = {num_mag, {FRAC_BITS{1'b0}}};
    dreq.divisor  = den;
  end

  assign mag = (quo > QUO_W'(COV_MAX)) ? COV_MAX : quo[47:0];

  scm_divider u_div (.clk(clk), .rst(rst), .req(dreq), .done(ddone), .quotient(quo));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      coord_index <= '0;
      point_count <= '0;
      dropped <= 1'b0;
      strobe <= 1'b0;
      ii <= '0;
      jj <= '0;
      for (int k = 0; k < MAX_DIM; k++) csum[k] <= '0;
    end else begin
      state <= state_next;
      strobe <= (state == S_EMIT);
      unique case (state)
        S_IDLE: if (start) begin
          ii <= '0;
          jj <= '0;
          if (cmd.action == ACT_COORD) pbuf[coord_index] <= cmd.coord;
        end
        S_ACC: begin
          if (coord_index >= d1) begin
            coord_index <= '0;
            if (point_count < 16'(MAX_POINTS)) begin
              point_count <= point_count + 16'd1;
              for (int k = 0; k < MAX_DIM; k++)
                if (IDX_W'(k) <= d1) csum[k] <= csum[k] + CSUM_W'(pbuf[k]);
            end else dropped <= 1'b1;
          end else coord_index <= coord_index + IDX_W'(1);
          jj <= '0;
        end
        S_ACC_RD: ;
        S_ACC_WR: begin
          if (jj == d1) begin
            ii <= ii + IDX_W'(1);
            jj <= ii + IDX_W'(1);
          end else jj <= jj + IDX_W'(1);
        end
        S_FIN: begin
          coord_index <= '0;
          den <= DEN_W'(point_count) * DEN_W'(point_count - 16'd1);
        end
        S_PROD: begin
          prod <= csum[ii] * csum[jj];
          wide <= $signed({1'b0, point_count}) * psum_q;
        end
        S_NUM: begin
          neg <= num[NUM_W-1];
        end
        S_DIV: ;
        S_EMIT: begin
          result.row <= ii;
          result.col <= jj;
          result.covariance <= few ? '0 : (neg ? -$signed(mag) : $signed(mag));
          result.status <= few ? ST_FEW : (dropped ? ST_DROP : ST_OK);
          result.last <= (ii == d1 && jj == d1);
          if (ii == d1 && jj == d1) begin
            ii <= '0;
            jj <= '0;
          end else if (jj == d1) begin
            jj <= '0;
            ii <= ii + IDX_W'(1);
          end else jj <= jj + IDX_W'(1);
        end
        S_CLR: begin
          if (jj == IDX_W'(MAX_DIM - 1)) begin
            ii <= ii + IDX_W'(1);
            jj <= ii + IDX_W'(1);
          end else jj <= jj + IDX_W'(1);
          if (ti == TRI_W'(TRI_SIZE - 1)) begin
            point_count <= '0;
            dropped <= 1'b0;
            for (int k = 0; k < MAX_DIM; k++) csum[k] <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  `SCM_ASSERT_IMP(a_cfg_idle, clk, rst, cfg_ready, !busy)
  `SCM_ASSERT_IMP(a_strobe_emit, clk, rst, strobe, $past(state) == S_EMIT)
  `SCM_ASSERT_NEXT(a_last_done, clk, rst, strobe && result.last, busy)
endmodule
